// ===== rtl/wsd_pkg.sv =====
// Package for the window stillness detector.
// Holds sizes, register indexes, request types and controller types.
// No dependencies.
package wsd_pkg;

  localparam int MAX_WINDOW = 128;
  localparam int COORD_BITS = 16;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int SEEN_W     = 8;
  localparam int WLEN_LIMIT = (MAX_WINDOW < 254) ? MAX_WINDOW : 254;
  localparam int SPAN_W     = COORD_BITS + 1;
  localparam int THR_W      = 16;
  localparam int CMP_W      = (SPAN_W > THR_W) ? SPAN_W : THR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TOTAL_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SPAN_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 2'd1;

  localparam logic [THR_W-1:0]  SPAN_THRESHOLD_RST = 16'd410;
  localparam logic [SEEN_W-1:0] WINDOW_LEN_RST     = 8'd100;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } wsd_in_t;

  typedef struct packed {
    logic               trapped;
    logic [TOTAL_W-1:0] trapped_total;
    logic               window_full;
  } wsd_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_FINISH
  } wsd_state_e;

  typedef struct packed {
    logic accept;
    logic issue;
    logic eval;
    logic load_out;
  } wsd_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } wsd_sts_t;

  function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    if (a == '0) begin
      r = ADDR_W'(MAX_WINDOW - 1);
    end else begin
      r = a - 1'b1;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    if (a == ADDR_W'(MAX_WINDOW - 1)) begin
      r = '0;
    end else begin
      r = a + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/wsd_ctrl.sv =====
// Controller state machine of the window stillness detector.
// Sequences accept, window scan, evaluation and result hand-off.
// Depends on wsd_pkg.
module wsd_ctrl import wsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  wsd_sts_t sts_i,
  output wsd_cmd_t cmd_o
);

  wsd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.issue = !sts_i.scan_done;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/wsd_datapath.sv =====
// Datapath of the window stillness detector: configuration registers,
// sample history memories, min/max scan, threshold test and output register.
// Depends on wsd_pkg; commanded by wsd_ctrl.
module wsd_datapath import wsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wsd_in_t               in_data_i,
  input  wsd_cmd_t              cmd_i,
  output wsd_sts_t              sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output wsd_out_t              out_data_o
);

  logic [THR_W-1:0]   thr_q;
  logic [SEEN_W-1:0]  wlen_q;
  logic [ADDR_W-1:0]  slot_q;
  logic [SEEN_W-1:0]  seen_q, seen_d;
  logic [SEEN_W-1:0]  cnt_q;
  logic [ADDR_W-1:0]  rd_ptr_q;
  logic               rd_vld_q;
  logic               full_q;
  logic               trapped_q;
  logic [TOTAL_W-1:0] count_q, count_d;
  logic               out_valid_q;
  wsd_out_t           out_q;
  logic [SEEN_W-1:0]  eff_w;
  logic               full_d;

  logic signed [COORD_BITS-1:0] x_mem [MAX_WINDOW];
  logic signed [COORD_BITS-1:0] y_mem [MAX_WINDOW];
  logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q;
  logic signed [COORD_BITS-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [COORD_BITS-1:0] cx, cy;
  logic [SPAN_W-1:0]            span_x, span_y;
  logic                         below;

  assign cx = $signed(in_data_i.pos_x[COORD_BITS-1:0]);
  assign cy = $signed(in_data_i.pos_y[COORD_BITS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= SPAN_THRESHOLD_RST;
      wlen_q <= WINDOW_LEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SPAN_THRESHOLD) begin
        thr_q <= cfg_data_i[THR_W-1:0];
      end else if (cfg_idx_i == REG_WINDOW_LEN) begin
        wlen_q <= cfg_data_i[SEEN_W-1:0];
      end
    end
  end

  always_comb begin
    priority if (wlen_q == '0) begin
      eff_w = SEEN_W'(1);
    end else if (wlen_q > SEEN_W'(WLEN_LIMIT)) begin
      eff_w = SEEN_W'(WLEN_LIMIT);
    end else begin
      eff_w = wlen_q;
    end
    seen_d = (seen_q == '1) ? seen_q : seen_q + 1'b1;
    full_d = seen_d > eff_w;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_mem[slot_q] <= cx;
      y_mem[slot_q] <= cy;
    end
    if (cmd_i.issue) begin
      rd_x_q <= x_mem[rd_ptr_q];
      rd_y_q <= y_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      seen_q   <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      full_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.accept) begin
        slot_q <= slot_inc(slot_q);
        seen_q <= seen_d;
        full_q <= full_d;
        cnt_q  <= full_d ? eff_w - 1'b1 : '0;
      end else if (cmd_i.issue) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_ptr_q <= slot_dec(slot_q);
      min_x_q  <= cx;
      max_x_q  <= cx;
      min_y_q  <= cy;
      max_y_q  <= cy;
    end else begin
      if (cmd_i.issue) begin
        rd_ptr_q <= slot_dec(rd_ptr_q);
      end
      if (rd_vld_q) begin
        if (rd_x_q < min_x_q) min_x_q <= rd_x_q;
        if (rd_x_q > max_x_q) max_x_q <= rd_x_q;
        if (rd_y_q < min_y_q) min_y_q <= rd_y_q;
        if (rd_y_q > max_y_q) max_y_q <= rd_y_q;
      end
    end
  end

  assign span_x = {max_x_q[COORD_BITS-1], max_x_q} - {min_x_q[COORD_BITS-1], min_x_q};
  assign span_y = {max_y_q[COORD_BITS-1], max_y_q} - {min_y_q[COORD_BITS-1], min_y_q};
  assign below  = (CMP_W'(span_x) < CMP_W'(thr_q)) && (CMP_W'(span_y) < CMP_W'(thr_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      trapped_q <= full_q && below;
    end
  end

  assign count_d = (trapped_q && (count_q != '1)) ? count_q + 1'b1 : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_out) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.trapped       <= trapped_q;
      out_q.trapped_total <= full_q ? count_d : '0;
      out_q.window_full   <= full_q;
    end
  end

  assign sts_o.scan_done = (cnt_q == '0);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

`ifndef NO_ASSERTIONS
  a_issue_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (cnt_q != '0))
    else $error("window read issued with no entries left");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an untaken result");
  a_trapped_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (!out_q.trapped || out_q.window_full))
    else $error("trapped flagged before window full");
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q >= $past(count_q)))
    else $error("trapped count decreased");
`endif

endmodule

// ===== rtl/window_stillness_detector.sv =====
// Window stillness detector top level: one request per position sample.
// Each accepted sample is scanned against the window history, evaluated and
// handed to the output register before the next sample is accepted.
// The scan walks the history memories through their single read port; while the
// window fills, the scan reads no history entries.
// Reset is asynchronous and active low; history contents are not cleared.
module window_stillness_detector import wsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  wsd_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output wsd_out_t              out_data_o
);

  wsd_cmd_t cmd;
  wsd_sts_t sts;

  wsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wsd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
